// ===== sv/weighted_range_sample_mapper_defines.svh =====
// Assertion macros used by the mapper's top-level RTL file.
`ifndef WEIGHTED_RANGE_SAMPLE_MAPPER_DEFINES_SVH
`define WEIGHTED_RANGE_SAMPLE_MAPPER_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define WRSM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define WRSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/wrsm_pkg.sv =====
`timescale 1ns / 1ps

package wrsm_pkg;

    localparam int DATA_W        = 32;
    localparam int COUNT_W       = 9;
    localparam int INDEX_W       = 8;
    localparam int MAX_ENTRIES   = 256;
    localparam int CELL_ENTRIES  = 16;
    localparam int N_CELLS       = MAX_ENTRIES / CELL_ENTRIES;
    localparam int LOCAL_W       = $clog2(CELL_ENTRIES);
    localparam int HOP_W         = INDEX_W - LOCAL_W;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_ADDR  = 2'd1;
    localparam logic [1:0] OP_PORT  = 2'd2;

    // A beat in flight along the cell chain. For a write, sel_base and
    // sel_end carry the data to be stored; for a lookup they carry the
    // entry picked so far.
    typedef struct packed {
        logic                valid;
        logic [1:0]          op;
        logic                hit;
        logic                wr_pend;
        logic [HOP_W-1:0]    hop;
        logic [LOCAL_W-1:0]  wr_local;
        logic [COUNT_W-1:0]  remain;
        logic [DATA_W-1:0]   key;
        logic [DATA_W-1:0]   sel_base;
        logic [DATA_W-1:0]   sel_end;
    } t_token;

endpackage

// ===== sv/wrsm_cell.sv =====
`timescale 1ns / 1ps

module wrsm_cell
    import wrsm_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_token i_tok,
    output t_token o_tok
);

    logic [DATA_W-1:0]   r_base [CELL_ENTRIES];
    logic [DATA_W-1:0]   r_end  [CELL_ENTRIES];
    t_token              r_tok;
    t_token              n_tok;
    logic [CELL_ENTRIES-1:0] v_hit;
    logic                wr_here;
    logic                search;

    // Compare the key against every local entry at once, then keep the
    // lowest slot that qualifies.
    always_comb begin
        n_tok   = i_tok;
        wr_here = i_tok.valid && (i_tok.op == OP_WRITE) && i_tok.wr_pend &&
                  (i_tok.hop == '0);
        search  = i_tok.valid && ((i_tok.op == OP_ADDR) || (i_tok.op == OP_PORT)) &&
                  !i_tok.hit;
        for (int j = 0; j < CELL_ENTRIES; j++) begin
            v_hit[j] = (COUNT_W'(j) < i_tok.remain) && (i_tok.key <= r_end[j]);
        end
        n_tok.hop = i_tok.hop - HOP_W'(1);
        if (wr_here) begin
            n_tok.wr_pend = 1'b0;
        end
        if (search && (|v_hit)) begin
            n_tok.hit = 1'b1;
            for (int j = CELL_ENTRIES - 1; j >= 0; j--) begin
                if (v_hit[j]) begin
                    n_tok.sel_base = r_base[j];
                    n_tok.sel_end  = r_end[j];
                end
            end
        end
        if (i_tok.remain > COUNT_W'(CELL_ENTRIES)) begin
            n_tok.remain = i_tok.remain - COUNT_W'(CELL_ENTRIES);
        end else begin
            n_tok.remain = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.op       <= n_tok.op;
        r_tok.hit      <= n_tok.hit;
        r_tok.wr_pend  <= n_tok.wr_pend;
        r_tok.hop      <= n_tok.hop;
        r_tok.wr_local <= n_tok.wr_local;
        r_tok.remain   <= n_tok.remain;
        r_tok.key      <= n_tok.key;
        r_tok.sel_base <= n_tok.sel_base;
        r_tok.sel_end  <= n_tok.sel_end;
    end

    always_ff @(posedge i_clk) begin
        if (wr_here) begin
            r_base[i_tok.wr_local] <= i_tok.sel_base;
            r_end[i_tok.wr_local]  <= i_tok.sel_end;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== sv/weighted_range_sample_mapper.sv =====
`timescale 1ns / 1ps
// Weighted range sample mapper.
// Input channel (i_in_valid / o_in_ready) carries one item per beat: a table
// write (opcode 0), an address-mode lookup (1) or a port-mode lookup (2).
// Output channel (o_out_valid / i_out_ready) returns exactly one result beat
// per item, in order: picked_value and found.
// The table lives in a chain of 16 cells of 16 entries each. Every item walks
// the whole chain, one cell per cycle: a write is stored by the cell that owns
// its slot, a lookup picks the first qualifying entry in slot order, and later
// cells pass an earlier hit along untouched.
// From acceptance an item passes the injection register, then each cell of
// the chain, then the output stage. One item is in the chain at a time,
// so a new item is accepted only once the previous one has left the last cell.
// The entry_count register is written through the APB-style port at any byte
// address from 0 to 3 and reads back its low 9 bits; values above 256 act as 256.
// Reset clears entry_count and all control state; table contents are
// undefined until written.
// When the receiver stalls, a finished result waits in the output register and
// the next item may still be accepted; if its result also finishes, it waits
// in a holding register and no further item is accepted until that one drains.
`include "weighted_range_sample_mapper_defines.svh"

module weighted_range_sample_mapper
    import wrsm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_opcode,
    input  logic [INDEX_W-1:0]  i_entry_index,
    input  logic [DATA_W-1:0]   i_entry_base,
    input  logic [DATA_W-1:0]   i_entry_end,
    input  logic [DATA_W-1:0]   i_draw,
    // Output channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [DATA_W-1:0]   o_picked_value,
    output logic                o_found,
    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    t_token              tok_chain [N_CELLS + 1];
    t_token              r_inj;
    t_token              n_inj;
    t_token              exit_tok;
    logic [COUNT_W-1:0]  r_count;
    logic [COUNT_W-1:0]  active;
    logic                r_busy;
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_value;
    logic                r_out_found;
    logic                r_hold_valid;
    logic [DATA_W-1:0]   r_hold_value;
    logic                r_hold_found;
    logic [DATA_W-1:0]   res_value;
    logic                in_acc;
    logic                out_take;
    logic                cfg_wr;

    // Configuration: one register, decoded on the word address only.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {{(32 - COUNT_W){1'b0}}, r_count} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (cfg_wr) begin
            r_count <= pwdata[COUNT_W-1:0];
        end
    end

    // Count of entries that lookups may search, limited to the table size.
    assign active = (r_count > COUNT_W'(MAX_ENTRIES)) ? COUNT_W'(MAX_ENTRIES) : r_count;

    // Only one item is in the chain at a time, and no item is taken while a
    // second finished result sits in the holding register.
    assign o_in_ready = !r_busy && !r_hold_valid;
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_take   = r_out_valid && i_out_ready;

    // Build the beat that enters the first cell. The write's found flag is
    // decided here, as the slot range is known at once.
    always_comb begin
        n_inj          = r_inj;
        n_inj.valid    = in_acc;
        n_inj.op       = i_opcode;
        n_inj.hit      = (i_opcode == OP_WRITE) &&
                         ({1'b0, i_entry_index} < (INDEX_W + 1)'(MAX_ENTRIES));
        n_inj.wr_pend  = (i_opcode == OP_WRITE);
        n_inj.hop      = i_entry_index[INDEX_W-1:LOCAL_W];
        n_inj.wr_local = i_entry_index[LOCAL_W-1:0];
        n_inj.remain   = active;
        n_inj.key      = i_draw;
        n_inj.sel_base = i_entry_base;
        n_inj.sel_end  = i_entry_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inj.valid <= 1'b0;
        end else begin
            r_inj.valid <= n_inj.valid;
        end
        if (in_acc) begin
            r_inj.op       <= n_inj.op;
            r_inj.hit      <= n_inj.hit;
            r_inj.wr_pend  <= n_inj.wr_pend;
            r_inj.hop      <= n_inj.hop;
            r_inj.wr_local <= n_inj.wr_local;
            r_inj.remain   <= n_inj.remain;
            r_inj.key      <= n_inj.key;
            r_inj.sel_base <= n_inj.sel_base;
            r_inj.sel_end  <= n_inj.sel_end;
        end
    end

    assign tok_chain[0] = r_inj;

    for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
        wrsm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (tok_chain[k]),
            .o_tok   (tok_chain[k + 1])
        );
    end

    assign exit_tok = tok_chain[N_CELLS];

    // Final mapping of the picked entry. Writes, misses and the unused
    // opcode all give zero.
    always_comb begin
        res_value = '0;
        if (exit_tok.hit) begin
            if (exit_tok.op == OP_ADDR) begin
                res_value = exit_tok.sel_base - exit_tok.sel_end + exit_tok.key;
            end else if (exit_tok.op == OP_PORT) begin
                res_value = exit_tok.sel_base;
            end
        end
    end

    // Busy runs from acceptance until the beat leaves the last cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (in_acc) begin
            r_busy <= 1'b1;
        end else if (exit_tok.valid) begin
            r_busy <= 1'b0;
        end
    end

    // Output register with a holding stage behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_hold_valid <= 1'b0;
        end else if (exit_tok.valid) begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_hold_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid  <= r_hold_valid;
            r_hold_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exit_tok.valid) begin
            if (!r_out_valid || out_take) begin
                r_out_value <= res_value;
                r_out_found <= exit_tok.hit;
            end else begin
                r_hold_value <= res_value;
                r_hold_found <= exit_tok.hit;
            end
        end else if (out_take && r_hold_valid) begin
            r_out_value <= r_hold_value;
            r_out_found <= r_hold_found;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_picked_value = r_out_value;
    assign o_found        = r_out_found;

    // A waiting second result always sits behind a first one.
    `WRSM_ASSERT_NOW(a_hold_behind_out, i_clk, i_rst_n, r_hold_valid, r_out_valid,
        "holding register full while output register empty")
    // Beats travel the chain only while an item is in progress.
    `WRSM_ASSERT_NOW(a_inj_busy, i_clk, i_rst_n, r_inj.valid, r_busy,
        "beat entered the chain while idle")
    `WRSM_ASSERT_NOW(a_exit_busy, i_clk, i_rst_n, exit_tok.valid, r_busy,
        "beat left the chain while idle")
    // A result leaving the chain must never find both stages full.
    `WRSM_ASSERT_NOW(a_no_overrun, i_clk, i_rst_n, exit_tok.valid, !r_hold_valid,
        "result left the chain with no room")
    `WRSM_ASSERT_NEXT(a_acc_inject, i_clk, i_rst_n, in_acc, r_inj.valid && r_busy,
        "accepted item did not enter the chain")

endmodule
